>>> hdl/hdg_pkg.sv
package hdg_pkg;

    // Field widths
    localparam int MAGW = 16;
    localparam int DW   = 15;
    localparam int DEGW = 9;

    // Datapath widths
    localparam int XW  = 19;   // CORDIC x/y, covers the gain of about 1.65 on a 17-bit vector
    localparam int ZW  = 32;   // accumulated angle, radians in Q30
    localparam int AW  = 36;   // angle plus declination, signed Q30
    localparam int UW  = 33;   // wrapped angle below 2*pi, unsigned Q30
    localparam int PW  = 41;   // angle * 180 and quotient * pi

    localparam int ATAN_N     = 24;
    localparam int DECL_SHIFT = 18;  // Q2.12 to Q30

    // Reciprocal estimate of angle * 180 / pi on the upper angle bits
    localparam int HI_SHIFT    = 8;
    localparam int HW          = UW - HI_SHIFT;
    localparam int RECIP_SHIFT = 40;
    localparam int RW          = 24;
    localparam int MW          = HW + RW;

    localparam longint unsigned PI_Q30      = 64'd3373259426;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned TWO_PI_Q30  = 64'd6746518852;
    localparam longint unsigned RECIP       =
        (64'd180 << (RECIP_SHIFT + HI_SHIFT)) / PI_Q30;

    localparam logic signed [AW-1:0] HALF_PI_A = AW'(HALF_PI_Q30);
    localparam logic signed [AW-1:0] PI_A      = AW'(PI_Q30);
    localparam logic signed [AW-1:0] TWO_PI_A  = AW'(TWO_PI_Q30);
    localparam logic [DEGW-1:0]      DEG_FULL  = DEGW'(360);
    localparam logic [7:0]           DEG_HALF  = 8'd180;

    // Octant pair the vector was turned out of
    typedef enum logic [1:0] {
        Q_EAST,
        Q_NORTH,
        Q_WEST,
        Q_SOUTH
    } t_quad;

    // One CORDIC pipeline stage
    typedef struct packed {
        logic                 valid;
        t_quad                quad;
        logic signed [XW-1:0] px;
        logic signed [XW-1:0] py;
        logic signed [ZW-1:0] z;
    } t_cordic;

    // atan(2^-i) in Q30, rounded to nearest
    function automatic logic [ZW-1:0] atan_q30(input int unsigned idx);
        logic [ZW-1:0] v;
        case (idx)
            0:       v = ZW'(843314857);
            1:       v = ZW'(497837829);
            2:       v = ZW'(263043837);
            3:       v = ZW'(133525159);
            4:       v = ZW'(67021687);
            5:       v = ZW'(33543516);
            6:       v = ZW'(16775851);
            7:       v = ZW'(8388437);
            8:       v = ZW'(4194283);
            9:       v = ZW'(2097149);
            10:      v = ZW'(1048576);
            11:      v = ZW'(524288);
            12:      v = ZW'(262144);
            13:      v = ZW'(131072);
            14:      v = ZW'(65536);
            15:      v = ZW'(32768);
            16:      v = ZW'(16384);
            17:      v = ZW'(8192);
            18:      v = ZW'(4096);
            19:      v = ZW'(2048);
            20:      v = ZW'(1024);
            21:      v = ZW'(512);
            22:      v = ZW'(256);
            23:      v = ZW'(128);
            default: v = '0;
        endcase
        return v;
    endfunction

    // Base angle of each quadrant in Q30
    function automatic logic signed [AW-1:0] base_angle(input t_quad q);
        logic signed [AW-1:0] v;
        unique case (q)
            Q_EAST:  v = '0;
            Q_NORTH: v = HALF_PI_A;
            Q_WEST:  v = PI_A;
            Q_SOUTH: v = -HALF_PI_A;
        endcase
        return v;
    endfunction

endpackage

>>> hdl/hdg_cordic_stage.sv
module hdg_cordic_stage #(
    parameter int unsigned ITER = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  hdg_pkg::t_cordic i_stage,
    output hdg_pkg::t_cordic o_stage
);
    import hdg_pkg::*;

    logic signed [XW-1:0] px;
    logic signed [XW-1:0] py;
    logic signed [ZW-1:0] z;
    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;
    logic signed [ZW-1:0] da;
    t_cordic              n_stage;
    t_cordic              r_stage;

    assign px = i_stage.px;
    assign py = i_stage.py;
    assign z  = i_stage.z;
    assign da = $signed(atan_q30(ITER));

    // Rotate toward the x axis; a vector already on it stays put
    always_comb begin
        dx      = py >>> ITER;
        dy      = px >>> ITER;
        n_stage = i_stage;
        if (py > 0) begin
            n_stage.px = px + dx;
            n_stage.py = py - dy;
            n_stage.z  = z + da;
        end else if (py < 0) begin
            n_stage.px = px - dx;
            n_stage.py = py + dy;
            n_stage.z  = z - da;
        end
    end

    // Advance one stage every cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else begin
            r_stage <= n_stage;
        end
    end

    assign o_stage = r_stage;

endmodule

>>> hdl/hdg_deg_conv.sv
module hdg_deg_conv (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  hdg_pkg::t_cordic               i_stage,
    input  logic signed [hdg_pkg::DW-1:0] i_decl,
    output logic                          o_valid,
    output logic [hdg_pkg::DEGW-1:0]      o_deg
);
    import hdg_pkg::*;

    logic [4:0]           r_vld;
    logic signed [AW-1:0] r_sum;
    logic [AW-2:0]        r_ang;
    logic                 r_over3;
    logic [MW-1:0]        r_mul;
    logic [PW-1:0]        r_a180_3;
    logic                 r_over4;
    logic [DEGW-1:0]      r_q;
    logic [PW-1:0]        r_qpi;
    logic [PW-1:0]        r_a180_4;
    logic [DEGW-1:0]      r_deg;

    logic signed [ZW-1:0] z_s;
    logic signed [DW-1:0] d_s;
    logic signed [AW-1:0] n_sum;
    logic signed [AW-1:0] wrapped;
    logic [DEGW-1:0]      n_q;
    logic [PW-1:0]        rem;
    logic [DEGW-1:0]      q_fix;
    logic [DEGW-1:0]      n_deg;

    assign z_s = i_stage.z;
    assign d_s = i_decl;

    // Sum quadrant base, CORDIC angle and declination
    assign n_sum = base_angle(i_stage.quad) + AW'(z_s) + (AW'(d_s) <<< DECL_SHIFT);

    // Wrap once into [0, 2*pi), clamp anything still negative
    always_comb begin
        if (r_sum >= TWO_PI_A) begin
            wrapped = r_sum - TWO_PI_A;
        end else if (r_sum < 0) begin
            wrapped = r_sum + TWO_PI_A;
        end else begin
            wrapped = r_sum;
        end
        if (wrapped < 0) begin
            wrapped = '0;
        end
    end

    // Quotient estimate is low by at most one; fix it from the remainder
    assign n_q   = r_mul[MW-1:RECIP_SHIFT];
    assign rem   = r_a180_4 - r_qpi;
    assign q_fix = (rem >= PW'(PI_Q30)) ? r_q + DEGW'(1) : r_q;
    assign n_deg = (r_over4 || q_fix >= DEG_FULL) ? '0 : q_fix;

    // Valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[3:0], i_stage.valid};
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_sum    <= n_sum;
        r_ang    <= wrapped[AW-2:0];
        r_over3  <= (r_ang >= (AW-1)'(TWO_PI_Q30));
        r_mul    <= MW'(r_ang[UW-1:HI_SHIFT]) * MW'(RECIP);
        r_a180_3 <= PW'(r_ang[UW-1:0]) * PW'(DEG_HALF);
        r_over4  <= r_over3;
        r_q      <= n_q;
        r_qpi    <= PW'(n_q) * PW'(PI_Q30);
        r_a180_4 <= r_a180_3;
        r_deg    <= n_deg;
    end

    assign o_valid = r_vld[4];
    assign o_deg   = r_deg;

endmodule

>>> hdl/compass_heading_from_magnetometer.sv
// Compass heading from one magnetometer X/Y sample pair.
//
// Input: a sample pair is taken at each rising edge with start high and busy
// low. busy is low except during reset, so a new pair can enter every cycle.
// Output: o_heading_valid is high for exactly one cycle with the heading in
// whole degrees (0..359) on o_heading_degrees; the receiver cannot stall and
// every pair yields exactly one heading, in order.
// Pipeline: the pair is registered after the quadrant turn, then passes
// through the CORDIC stage registers and the sum, wrap and degree
// conversion registers. Throughput is one pair per cycle, set by the fully
// unrolled CORDIC pipeline.
// Configuration: the declination (Q2.12 radians) is written on its own
// valid/ready channel, ready whenever out of reset; write it only while no
// transaction is in flight.
// Reset: clears the declination to 0 and drops all transactions in flight.
module compass_heading_from_magnetometer #(
    parameter int ANGLE_ITERATIONS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic signed [hdg_pkg::MAGW-1:0] i_mag_x,
    input  logic signed [hdg_pkg::MAGW-1:0] i_mag_y,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic signed [hdg_pkg::DW-1:0]   i_declination_offset,
    output logic                            o_heading_valid,
    output logic [hdg_pkg::DEGW-1:0]        o_heading_degrees
);
    import hdg_pkg::*;

    localparam int N_EFF = (ANGLE_ITERATIONS > ATAN_N) ? ATAN_N : ANGLE_ITERATIONS;
    localparam int LAT   = N_EFF + 6;

    logic signed [DW-1:0] r_decl;
    logic signed [XW-1:0] xe;
    logic signed [XW-1:0] ye;
    logic                 accept;
    t_cordic              n_st0;
    t_cordic              r_st0;
    t_cordic              st [N_EFF+1];

    assign busy        = ~i_rst_n;
    assign o_cfg_ready = i_rst_n;
    assign accept      = start & ~busy;

    // Hold the declination register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decl <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_decl <= i_declination_offset;
        end
    end

    assign xe = XW'(i_mag_x);
    assign ye = XW'(i_mag_y);

    // Turn a nonzero vector into x > 0, y >= 0 by a multiple of pi/2
    always_comb begin
        n_st0.valid = accept;
        n_st0.z     = '0;
        if (xe == 0 && ye == 0) begin
            n_st0.quad = Q_EAST;
            n_st0.px   = '0;
            n_st0.py   = '0;
        end else if (xe > 0 && ye >= 0) begin
            n_st0.quad = Q_EAST;
            n_st0.px   = xe;
            n_st0.py   = ye;
        end else if (xe <= 0 && ye > 0) begin
            n_st0.quad = Q_NORTH;
            n_st0.px   = ye;
            n_st0.py   = -xe;
        end else if (xe < 0 && ye <= 0) begin
            n_st0.quad = Q_WEST;
            n_st0.px   = -xe;
            n_st0.py   = -ye;
        end else begin
            n_st0.quad = Q_SOUTH;
            n_st0.px   = -ye;
            n_st0.py   = xe;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st0.valid <= 1'b0;
        end else begin
            r_st0 <= n_st0;
        end
    end

    assign st[0] = r_st0;

    // Unrolled CORDIC vectoring, one iteration per stage
    for (genvar i = 0; i < N_EFF; i++) begin : g_cordic
        hdg_cordic_stage #(
            .ITER(i)
        ) u_stage (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_stage(st[i]),
            .o_stage(st[i+1])
        );
    end

    // Add declination, wrap and convert to degrees
    hdg_deg_conv u_deg (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_stage(st[N_EFF]),
        .i_decl (r_decl),
        .o_valid(o_heading_valid),
        .o_deg  (o_heading_degrees)
    );

    // Every accepted transaction gives a heading
    a_lat_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##LAT o_heading_valid)
        else $error("heading missing after accepted sample");

    // No heading without an accepted transaction before it
    a_lat_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_heading_valid |-> $past(accept, LAT))
        else $error("heading without a sample");

    // Heading stays below a full turn
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_heading_valid |-> (o_heading_degrees < DEG_FULL))
        else $error("heading out of range");

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int ITERATIONS  = 16;
    localparam int LATENCY     = ITERATIONS + 6;
    localparam int STALL_LIMIT = 4000;
    localparam int PHASES      = 9;
    localparam int PER_PHASE   = 67;

    // Angle constants in Q30 radians
    localparam longint PI_FX      = 64'sd3373259426;
    localparam longint HALF_PI_FX = 64'sd1686629713;
    localparam longint TWO_PI_FX  = 64'sd6746518852;

    typedef struct {
        logic signed [hdg_pkg::MAGW-1:0] x;
        logic signed [hdg_pkg::MAGW-1:0] y;
    } mag_sample_t;

    typedef struct {
        mag_sample_t                    s;
        logic signed [hdg_pkg::DW-1:0]  decl;
        logic [hdg_pkg::DEGW-1:0]       deg;
    } heading_due_t;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            start = 1'b0;
    logic                            busy;
    logic signed [hdg_pkg::MAGW-1:0] i_mag_x = '0;
    logic signed [hdg_pkg::MAGW-1:0] i_mag_y = '0;
    logic                            i_cfg_valid = 1'b0;
    logic                            o_cfg_ready;
    logic signed [hdg_pkg::DW-1:0]   i_declination_offset = '0;
    logic                            o_heading_valid;
    logic [hdg_pkg::DEGW-1:0]        o_heading_degrees;

    mag_sample_t                   samples_to_send[$];
    heading_due_t                  headings_due[$];
    logic signed [hdg_pkg::DW-1:0] declination_q12 = '0;
    int                            sender_idle_pct = 30;
    int                            error_count = 0;
    int                            samples_sent = 0;
    int                            headings_checked = 0;
    int                            cfg_writes = 0;
    int                            stall_cycles = 0;

    compass_heading_from_magnetometer #(
        .ANGLE_ITERATIONS(ITERATIONS)
    ) uut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .start                (start),
        .busy                 (busy),
        .i_mag_x              (i_mag_x),
        .i_mag_y              (i_mag_y),
        .i_cfg_valid          (i_cfg_valid),
        .o_cfg_ready          (o_cfg_ready),
        .i_declination_offset (i_declination_offset),
        .o_heading_valid      (o_heading_valid),
        .o_heading_degrees    (o_heading_degrees)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // atan(2^-i) in Q30, rounded to nearest
    function automatic longint arctan_step(input int i);
        longint v;
        case (i)
            0:  v = 843314857;
            1:  v = 497837829;
            2:  v = 263043837;
            3:  v = 133525159;
            4:  v = 67021687;
            5:  v = 33543516;
            6:  v = 16775851;
            7:  v = 8388437;
            8:  v = 4194283;
            9:  v = 2097149;
            10: v = 1048576;
            default: v = longint'(1) << (30 - i);
        endcase
        return v;
    endfunction

    // Turn into the first quadrant, run the vectoring stages, add the
    // declination, wrap once and convert to whole degrees
    function automatic logic [hdg_pkg::DEGW-1:0] heading_from_sample(
        input mag_sample_t s, input logic signed [hdg_pkg::DW-1:0] decl);
        longint         x, y, px, py, dx, dy, z, base, angle;
        longint         deg;
        int             n, i;
        hdg_pkg::t_quad quad;
        x = s.x;
        y = s.y;
        z = 0;
        px = 0;
        py = 0;
        if (x == 0 && y == 0) begin
            angle = 0;
        end else begin
            if (x > 0 && y >= 0) begin
                quad = hdg_pkg::Q_EAST;  px = x;  py = y;
            end else if (x <= 0 && y > 0) begin
                quad = hdg_pkg::Q_NORTH; px = y;  py = -x;
            end else if (x < 0 && y <= 0) begin
                quad = hdg_pkg::Q_WEST;  px = -x; py = -y;
            end else begin
                quad = hdg_pkg::Q_SOUTH; px = -y; py = x;
            end
            n = (ITERATIONS > 24) ? 24 : ITERATIONS;
            for (i = 0; i < n; i++) begin
                dx = py >>> i;
                dy = px >>> i;
                if (py > 0) begin
                    px = px + dx; py = py - dy; z = z + arctan_step(i);
                end else if (py < 0) begin
                    px = px - dx; py = py + dy; z = z - arctan_step(i);
                end
            end
            case (quad)
                hdg_pkg::Q_EAST:  base = 0;
                hdg_pkg::Q_NORTH: base = HALF_PI_FX;
                hdg_pkg::Q_WEST:  base = PI_FX;
                default:          base = -HALF_PI_FX;
            endcase
            angle = base + z;
        end
        angle = angle + longint'(decl) * 262144;
        if (angle >= TWO_PI_FX)
            angle = angle - TWO_PI_FX;
        else if (angle < 0)
            angle = angle + TWO_PI_FX;
        if (angle < 0)
            angle = 0;
        deg = (angle * 180) / PI_FX;
        if (deg >= 360)
            deg = 0;
        return deg[hdg_pkg::DEGW-1:0];
    endfunction

    function automatic logic signed [hdg_pkg::MAGW-1:0] extreme_value();
        logic signed [hdg_pkg::MAGW-1:0] v;
        case ($urandom_range(4))
            0:       v = -16'sd32768;
            1:       v = -16'sd1;
            2:       v = 16'sd0;
            3:       v = 16'sd1;
            default: v = 16'sd32767;
        endcase
        return v;
    endfunction

    // Full-range pairs half the time, plus axes, diagonals, tiny vectors, extremes and
    // vectors just below the positive X axis that wrap
    function automatic mag_sample_t random_sample();
        mag_sample_t                     s;
        logic signed [hdg_pkg::MAGW-1:0] m;
        s.x = hdg_pkg::MAGW'($urandom);
        s.y = hdg_pkg::MAGW'($urandom);
        m = hdg_pkg::MAGW'($urandom);
        case ($urandom_range(9))
            5: begin
                s.x = hdg_pkg::MAGW'($urandom_range(16) - 8);
                s.y = hdg_pkg::MAGW'($urandom_range(16) - 8);
            end
            6: begin
                if ($urandom_range(1))
                    s.y = '0;
                else
                    s.x = '0;
            end
            7: begin
                s.x = m;
                s.y = $urandom_range(1) ? m : -m;
            end
            8: begin
                s.x = extreme_value();
                s.y = extreme_value();
            end
            9: begin
                s.x = hdg_pkg::MAGW'($urandom_range(32767, 1000));
                s.y = hdg_pkg::MAGW'(0 - $urandom_range(40));
            end
            default: ;
        endcase
        return s;
    endfunction

    task automatic queue_sample(input int x, input int y);
        mag_sample_t s;
        s.x = hdg_pkg::MAGW'(x);
        s.y = hdg_pkg::MAGW'(y);
        samples_to_send.push_back(s);
    endtask

    task automatic wait_for_drain();
        while (samples_to_send.size() != 0 || headings_due.size() != 0)
            @(posedge i_clk);
    endtask

    // Write the declination register over its own channel
    task automatic write_declination(input logic signed [hdg_pkg::DW-1:0] v);
        i_cfg_valid <= 1'b1;
        i_declination_offset <= v;
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        declination_q12 = v;
        cfg_writes++;
    endtask

    // Sample driver: record each transaction as it is taken, then load the
    // next pair or idle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                headings_due.push_back('{s: '{x: i_mag_x, y: i_mag_y},
                    decl: declination_q12,
                    deg: heading_from_sample('{x: i_mag_x, y: i_mag_y}, declination_q12)});
                samples_sent++;
            end
            if (!start || !busy) begin
                if (samples_to_send.size() != 0 &&
                        $urandom_range(99) >= sender_idle_pct) begin
                    i_mag_x <= samples_to_send[0].x;
                    i_mag_y <= samples_to_send[0].y;
                    void'(samples_to_send.pop_front());
                    start <= 1'b1;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Heading monitor: compare each result with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_heading_valid) begin
            if (headings_due.size() == 0) begin
                error_count++;
                if (error_count <= 10)
                    $display("unexpected heading %0d with nothing pending",
                             o_heading_degrees);
            end else begin
                if (o_heading_degrees !== headings_due[0].deg) begin
                    error_count++;
                    if (error_count <= 10)
                        $display({"heading mismatch x=%0d y=%0d decl=%0d: ",
                                  "expected %0d got %0d"},
                                 headings_due[0].s.x, headings_due[0].s.y,
                                 headings_due[0].decl, headings_due[0].deg,
                                 o_heading_degrees);
                end
                headings_checked++;
                void'(headings_due.pop_front());
            end
        end
    end

    // Watchdog: end the run when no transaction moves for too long
    always @(posedge i_clk) begin
        if ((start && !busy) || o_heading_valid || (i_cfg_valid && o_cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
            $display("testbench: FAIL");
            $finish;
        end
    end

    initial begin
        logic signed [hdg_pkg::DW-1:0] decl_plan [PHASES];
        int                            p, k;
        decl_plan[0] = '0;
        decl_plan[1] = 15'sd12868;
        decl_plan[2] = -15'sd12868;
        decl_plan[3] = 15'sd16383;
        decl_plan[4] = -15'sd16384;
        decl_plan[5] = 15'sd1;
        decl_plan[6] = hdg_pkg::DW'($urandom_range(25736) - 12868);
        decl_plan[7] = -15'sd1;
        decl_plan[8] = hdg_pkg::DW'($urandom_range(25736) - 12868);

        // Hold reset, then release it
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Axes, extremes, diagonals and the zero vector at reset declination
        queue_sample(0, 0);
        queue_sample(32767, 0);
        queue_sample(-32768, 0);
        queue_sample(0, 32767);
        queue_sample(0, -32768);
        queue_sample(1, 0);
        queue_sample(0, 1);
        queue_sample(-1, 0);
        queue_sample(0, -1);
        queue_sample(100, 100);
        queue_sample(-100, 100);
        queue_sample(-100, -100);
        queue_sample(100, -100);
        queue_sample(32767, 32767);
        queue_sample(-32768, -32768);
        queue_sample(-32768, 32767);
        queue_sample(32767, -32768);
        queue_sample(1, -1);
        queue_sample(-1, 1);
        queue_sample(32767, -1);
        for (k = 0; k < PER_PHASE - 20; k++)
            samples_to_send.push_back(random_sample());

        for (p = 1; p < PHASES; p++) begin
            // Drain the pipeline before touching the declination
            wait_for_drain();
            repeat (LATENCY + 4) @(posedge i_clk);
            sender_idle_pct = (p < 3) ? 30 : (p < 6) ? 88 : 0;
            write_declination(decl_plan[p]);
            queue_sample(0, 0);
            queue_sample(32767, -1);
            for (k = 0; k < PER_PHASE - 2; k++)
                samples_to_send.push_back(random_sample());
        end

        wait_for_drain();
        repeat (LATENCY + 4) @(posedge i_clk);
        $display("covered %0d sample pairs over %0d declination settings, %0d writes",
                 samples_sent, PHASES, cfg_writes);
        $display("checked %0d headings, %0d mismatches", headings_checked, error_count);
        if (error_count == 0 && headings_due.size() == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule

>>> compass_heading_from_magnetometer.f
hdl/hdg_pkg.sv
hdl/hdg_cordic_stage.sv
hdl/hdg_deg_conv.sv
hdl/compass_heading_from_magnetometer.sv
tb/testbench.sv
